[rtl/stable_max_priority_queue_core_defines.svh]
// Assertion macros for the stable max priority queue core
`ifndef STABLE_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
// property must hold at every edge outside reset
`define SMPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define SMPQ_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SMPQ_ASSERT(label, clk, rst, prop, msg)
`define SMPQ_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/smpq_pkg.sv]
// Shared types and constants for the stable max priority queue core
package smpq_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] TAG_LIMIT = 3'd4;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_ASSIGN = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADTAG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2,
      OP_TAG    = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [7:0] key;
      logic [7:0] id;
      logic [1:0] tag;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
      logic [1:0]  tag;
   } cell_ctrl_type;

endpackage

[rtl/smpq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts with its neighbors
module smpq_cell
   import smpq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occ,
   input  logic          head_sel,
   input  logic          left_keep,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output entry_type     entry_next,
   output logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // an occupied slot with key >= new key keeps its place (stable order)
   assign keep = occ && (entry_ff.key >= ctrl.new_entry.key);

   // next slot content
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (!keep) begin
               entry_in = left_keep ? ctrl.new_entry : left_entry;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_TAG: begin
            if (head_sel) begin
               entry_in.tag = ctrl.tag;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

[rtl/stable_max_priority_queue_core.sv]
// Stable max priority queue: a chain of DEPTH cells kept sorted by key.
// A result word is registered and shows in the cycle after its word is accepted.
// One word per cycle when not stalled; every cell compares and shifts in parallel.
// The output register frees again in the cycle its word is taken.
// Reset clears the entry count and the output valid; cell contents are not cleared.
`include "stable_max_priority_queue_core_defines.svh"
module stable_max_priority_queue_core
   import smpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_entry_key,
   input  logic [7:0] req_entry_id,
   input  logic [2:0] req_tag_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_head_valid,
   output logic [7:0] rsp_head_key,
   output logic [7:0] rsp_head_id,
   output logic [1:0] rsp_head_tag,
   output logic [6:0] rsp_entry_count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic             rsp_head_valid_ff;
   entry_type        rsp_head_ff;
   logic [6:0]       rsp_count_ff;

   logic          fire;
   logic          full;
   logic          empty;
   status_type    status;
   cell_ctrl_type ctrl;
   logic          head_valid;
   entry_type     head;

   entry_type        cell_entry [DEPTH];
   entry_type        cell_next  [DEPTH];
   logic [DEPTH-1:0] cell_keep;
   logic [DEPTH-1:0] cell_occ;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   // decode the word into a cell operation, status and next count
   always_comb begin
      ctrl.op                = OP_HOLD;
      ctrl.new_entry.key     = req_entry_key;
      ctrl.new_entry.id      = req_entry_id;
      ctrl.new_entry.tag     = 2'd0;
      ctrl.tag               = req_tag_value[1:0];
      status                 = ST_OK;
      count_in               = count_ff;
      case (req_command)
         CMD_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else if (fire) begin
               ctrl.op  = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (fire) begin
               ctrl.op  = OP_POP;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_ASSIGN: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (req_tag_value >= TAG_LIMIT) begin
               status = ST_BADTAG;
            end else if (fire) begin
               ctrl.op = OP_TAG;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         smpq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occ         (cell_occ[i]),
            .head_sel    (1'b1),
            .left_keep   (1'b1),
            .left_entry  ('0),
            .right_entry ((DEPTH > 1) ? cell_entry[(i + 1) % DEPTH] : '0),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .keep        (cell_keep[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         smpq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occ         (cell_occ[i]),
            .head_sel    (1'b0),
            .left_keep   (cell_keep[i - 1]),
            .left_entry  (cell_entry[i - 1]),
            .right_entry ('0),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .keep        (cell_keep[i])
         );
      end else begin : g_mid
         smpq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occ         (cell_occ[i]),
            .head_sel    (1'b0),
            .left_keep   (cell_keep[i - 1]),
            .left_entry  (cell_entry[i - 1]),
            .right_entry (cell_entry[i + 1]),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .keep        (cell_keep[i])
         );
      end
   end

   // reported head: removed entry on a pop, else head after the operation
   always_comb begin
      if (ctrl.op == OP_POP) begin
         head_valid = 1'b1;
         head       = cell_entry[0];
      end else begin
         head_valid = (count_in != '0);
         head       = head_valid ? cell_next[0] : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff     <= status;
         rsp_head_valid_ff <= head_valid;
         rsp_head_ff       <= head;
         rsp_count_ff      <= 7'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_key    = rsp_head_ff.key;
   assign rsp_head_id     = rsp_head_ff.id;
   assign rsp_head_tag    = rsp_head_ff.tag;
   assign rsp_entry_count = rsp_count_ff;

   // checks
   `SMPQ_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "count above depth")
   `SMPQ_ASSERT(a_insert_count, clock, reset, (fire && ctrl.op == OP_INSERT) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not bump count")
   `SMPQ_ASSERT(a_fire_rsp, clock, reset, fire |=> rsp_valid_ff, "accepted word gave no result")
   `SMPQ_NEVER(a_head_zero, clock, reset, rsp_valid_ff && !rsp_head_valid_ff && (rsp_head_ff != '0), "invalid head not zero")

endmodule
